// File: sv/axuf_pkg.sv
// ----------------------------------------------------------------------------
// axuf_pkg - shared types and constants of the AX.25 UI fragment framer
// Segment size, header layout constants, CSR indexes and the queue entry type.
// ----------------------------------------------------------------------------
package axuf_pkg;

   localparam int unsigned MAX_DATAGRAM = 2048;
   localparam int unsigned SEGMENT      = 250;
   localparam int unsigned HDR_LEN      = 18;
   localparam int unsigned QUEUE_DEPTH  = 4;

   localparam int unsigned LEN_W  = 12;
   localparam int unsigned DPOS_W = 11;
   localparam int unsigned SPOS_W = 8;
   localparam int unsigned HCNT_W = 5;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] DSSID_BITS = 8'hE0;
   localparam logic [7:0] SSSID_BITS = 8'h60;
   localparam logic [7:0] SSID_CMD   = 8'h01;
   localparam logic [7:0] CTRL_UI    = 8'h03;
   localparam logic [7:0] PID_NONE   = 8'hF0;
   localparam logic [7:0] FRAG_MARK  = 8'h01;
   localparam logic [7:0] LAST_FRAG  = 8'h80;
   localparam logic [3:0] SEQ_WRAP   = 4'h0F;

   localparam logic [47:0] SPACES6 = 48'h2020_2020_2020;

   typedef enum logic [1:0] {
      CSR_DEST_CALL = 2'd0,
      CSR_DEST_SSID = 2'd1,
      CSR_SRC_CALL  = 2'd2,
      CSR_SRC_SSID  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [47:0] dest_callsign;
      logic [3:0]  dest_ssid;
      logic [47:0] src_callsign;
      logic [3:0]  src_ssid;
   } cfg_type;

   // one accepted byte, already classified by the front end
   typedef struct packed {
      logic [7:0] data_byte;
      logic       header;
      logic [7:0] frag_byte;
      logic       frame_end;
   } desc_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

// File: sv/axuf_front.sv
// ----------------------------------------------------------------------------
// axuf_front - input side of the framer
// Tracks datagram and segment position, classifies each byte and queues it.
// ----------------------------------------------------------------------------
module axuf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [7:0]                   req_data_byte,
   input  logic [11:0]                  req_datagram_length,
   input  logic                         queue_full,
   output logic                         push,
   output axuf_pkg::desc_type           push_desc
);

   logic [axuf_pkg::DPOS_W-1:0] dpos_ff, dpos_in;
   logic [axuf_pkg::SPOS_W-1:0] spos_ff, spos_in;
   logic [3:0]                  frag_ff, frag_in;
   logic [3:0]                  seq_ff,  seq_in;

   logic [axuf_pkg::LEN_W-1:0]  len;
   logic [axuf_pkg::LEN_W-1:0]  dpos_ext;
   logic                        last_seg;
   logic                        dgram_end;
   logic                        seg_end;

   assign push = req_valid && !queue_full;

   always_comb begin
      // zero counts as one byte, long lengths saturate
      if (req_datagram_length == '0) begin
         len = axuf_pkg::LEN_W'(1);
      end else if (req_datagram_length > axuf_pkg::LEN_W'(axuf_pkg::MAX_DATAGRAM)) begin
         len = axuf_pkg::LEN_W'(axuf_pkg::MAX_DATAGRAM);
      end else begin
         len = req_datagram_length;
      end
      dpos_ext  = axuf_pkg::LEN_W'(dpos_ff);
      last_seg  = (dpos_ext + axuf_pkg::LEN_W'(axuf_pkg::SEGMENT)) >= len;
      dgram_end = (dpos_ext + axuf_pkg::LEN_W'(1)) >= len;
      seg_end   = dgram_end ||
                  ((9'(spos_ff) + 9'd1) >= 9'(axuf_pkg::SEGMENT));

      push_desc.data_byte = req_data_byte;
      push_desc.header    = (spos_ff == '0);
      push_desc.frag_byte = {1'b0, seq_ff, 3'b000} | {4'b0000, frag_ff} |
                            (last_seg ? axuf_pkg::LAST_FRAG : 8'h00);
      push_desc.frame_end = seg_end;

      dpos_in = dpos_ff;
      spos_in = spos_ff;
      frag_in = frag_ff;
      seq_in  = seq_ff;
      if (push) begin
         if (dgram_end) begin
            dpos_in = '0;
            spos_in = '0;
            frag_in = '0;
            seq_in  = (seq_ff + 4'd1 >= axuf_pkg::SEQ_WRAP) ? 4'd0 : seq_ff + 4'd1;
         end else begin
            dpos_in = dpos_ff + axuf_pkg::DPOS_W'(1);
            if (seg_end) begin
               spos_in = '0;
               frag_in = frag_ff + 4'd1;
            end else begin
               spos_in = spos_ff + axuf_pkg::SPOS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dpos_ff <= '0;
         spos_ff <= '0;
         frag_ff <= '0;
         seq_ff  <= '0;
      end else begin
         dpos_ff <= dpos_in;
         spos_ff <= spos_in;
         frag_ff <= frag_in;
         seq_ff  <= seq_in;
      end
   end

endmodule

// File: sv/axuf_queue.sv
// ----------------------------------------------------------------------------
// axuf_queue - short descriptor queue between front and back
// Circular buffer; head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module axuf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  axuf_pkg::desc_type            push_desc,
   input  logic                          pop,
   output axuf_pkg::desc_type            head,
   output axuf_pkg::queue_status_type    status
);

   axuf_pkg::desc_type              mem_ff [axuf_pkg::QUEUE_DEPTH];
   logic [axuf_pkg::QPTR_W-1:0]     wptr_ff, wptr_in;
   logic [axuf_pkg::QPTR_W-1:0]     rptr_ff, rptr_in;
   logic [axuf_pkg::QCNT_W-1:0]     cnt_ff,  cnt_in;

   assign head             = mem_ff[rptr_ff];
   assign status.not_empty = (cnt_ff != '0);
   assign status.full      = (cnt_ff == axuf_pkg::QCNT_W'(axuf_pkg::QUEUE_DEPTH));

   always_comb begin
      wptr_in = push ? wptr_ff + axuf_pkg::QPTR_W'(1) : wptr_ff;
      rptr_in = pop  ? rptr_ff + axuf_pkg::QPTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + axuf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - axuf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: sv/axuf_back.sv
// ----------------------------------------------------------------------------
// axuf_back - output side of the framer
// Plays out the 18-byte UI header where needed, then the data byte.
// ----------------------------------------------------------------------------
module axuf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  axuf_pkg::cfg_type            cfg,
   input  axuf_pkg::desc_type           head,
   input  axuf_pkg::queue_status_type   qstat,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_frame_end,
   output logic                         rsp_run_last
);

   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        fend_ff, fend_in;
   logic                        last_ff, last_in;
   logic [axuf_pkg::HCNT_W-1:0] hcnt_ff, hcnt_in;

   logic                        load;
   logic                        in_header;
   logic [7:0]                  hdr_byte;

   assign load      = (!valid_ff || !rsp_stall) && qstat.not_empty;
   assign in_header = head.header &&
                      (hcnt_ff < axuf_pkg::HCNT_W'(axuf_pkg::HDR_LEN));
   assign pop       = load && !in_header;

   // callsign characters lose bit 7 in the shift
   always_comb begin
      case (hcnt_ff)
         5'd0:    hdr_byte = {cfg.dest_callsign[46:40], 1'b0};
         5'd1:    hdr_byte = {cfg.dest_callsign[38:32], 1'b0};
         5'd2:    hdr_byte = {cfg.dest_callsign[30:24], 1'b0};
         5'd3:    hdr_byte = {cfg.dest_callsign[22:16], 1'b0};
         5'd4:    hdr_byte = {cfg.dest_callsign[14:8],  1'b0};
         5'd5:    hdr_byte = {cfg.dest_callsign[6:0],   1'b0};
         5'd6:    hdr_byte = {3'b000, cfg.dest_ssid, 1'b0} | axuf_pkg::DSSID_BITS;
         5'd7:    hdr_byte = {cfg.src_callsign[46:40], 1'b0};
         5'd8:    hdr_byte = {cfg.src_callsign[38:32], 1'b0};
         5'd9:    hdr_byte = {cfg.src_callsign[30:24], 1'b0};
         5'd10:   hdr_byte = {cfg.src_callsign[22:16], 1'b0};
         5'd11:   hdr_byte = {cfg.src_callsign[14:8],  1'b0};
         5'd12:   hdr_byte = {cfg.src_callsign[6:0],   1'b0};
         5'd13:   hdr_byte = {3'b000, cfg.src_ssid, 1'b0} | axuf_pkg::SSSID_BITS |
                             axuf_pkg::SSID_CMD;
         5'd14:   hdr_byte = axuf_pkg::CTRL_UI;
         5'd15:   hdr_byte = axuf_pkg::PID_NONE;
         5'd16:   hdr_byte = axuf_pkg::FRAG_MARK;
         5'd17:   hdr_byte = head.frag_byte;
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      byte_in  = byte_ff;
      fend_in  = fend_ff;
      last_in  = last_ff;
      hcnt_in  = hcnt_ff;
      if (load) begin
         valid_in = 1'b1;
         if (in_header) begin
            byte_in = hdr_byte;
            fend_in = 1'b0;
            last_in = 1'b0;
            hcnt_in = hcnt_ff + axuf_pkg::HCNT_W'(1);
         end else begin
            byte_in = head.data_byte;
            fend_in = head.frame_end;
            last_in = 1'b1;
            hcnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hcnt_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         hcnt_ff  <= hcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      fend_ff <= fend_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = fend_ff;
   assign rsp_run_last  = last_ff;

   // header bytes never close a frame
   a_fend_on_data: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && fend_ff) |-> last_ff)
      else $error("frame end on a header byte");

   a_hcnt_range: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= axuf_pkg::HCNT_W'(axuf_pkg::HDR_LEN))
      else $error("header counter out of range");

   // mid-header the descriptor must still sit at the queue head
   a_hdr_holds_desc: assert property (@(posedge clock) disable iff (reset)
      (hcnt_ff != '0) |-> (qstat.not_empty && head.header))
      else $error("header underway without its descriptor");

   a_pop_ends_item: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff && hcnt_ff == '0))
      else $error("pop without a data byte loaded");

endmodule

// File: sv/ax25_ui_fragment_framer.sv
// ----------------------------------------------------------------------------
// ax25_ui_fragment_framer - AX.25 UI framing of datagrams, cut into segments
// Datagram bytes in, UI frame bytes out, with an 18-byte header per segment.
// ----------------------------------------------------------------------------
//  - req_: one datagram byte per item with the datagram's total length;
//    accepted when req_valid is high and req_stall low.
//  - rsp_: one frame byte per item; frame_end on a frame's last byte,
//    run_last on the data byte that closes each input's results.
//  - csr_: callsigns and SSIDs by index; csr_ready is always high. Write
//    only while the block is idle.
//  - Path: an accepted byte is written into the queue, then loaded from the
//    queue head into the output register; earlier queued bytes or a held
//    output register can delay that load.
//  - Throughput: one output byte per cycle while rsp_stall is low and a
//    byte is queued. A segment's first byte gives the 18-byte header and
//    its data byte, any other byte one. The four-entry queue takes bytes
//    while a header plays out or rsp_stall holds the output register; once
//    it fills, req_stall rises. Nothing is dropped.
//  - Reset (synchronous): queue and output empty, positions and sequence
//    zero, callsigns six spaces, SSIDs zero.
// ----------------------------------------------------------------------------
module ax25_ui_fragment_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [11:0] req_datagram_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   axuf_pkg::cfg_type           cfg_ff, cfg_in;
   axuf_pkg::desc_type          push_desc;
   axuf_pkg::desc_type          head;
   axuf_pkg::queue_status_type  qstat;
   logic                        push;
   logic                        pop;

   assign csr_ready = 1'b1;
   assign req_stall = qstat.full;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (axuf_pkg::csr_index_type'(csr_index))
            axuf_pkg::CSR_DEST_CALL: cfg_in.dest_callsign = csr_data;
            axuf_pkg::CSR_DEST_SSID: cfg_in.dest_ssid     = csr_data[3:0];
            axuf_pkg::CSR_SRC_CALL:  cfg_in.src_callsign  = csr_data;
            axuf_pkg::CSR_SRC_SSID:  cfg_in.src_ssid      = csr_data[3:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_callsign <= axuf_pkg::SPACES6;
         cfg_ff.dest_ssid     <= '0;
         cfg_ff.src_callsign  <= axuf_pkg::SPACES6;
         cfg_ff.src_ssid      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: position tracking and classification
   axuf_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_data_byte       (req_data_byte),
      .req_datagram_length (req_datagram_length),
      .queue_full          (qstat.full),
      .push                (push),
      .push_desc           (push_desc)
   );

   // decoupling queue
   axuf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (qstat)
   );

   // back: header playout and output register
   axuf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head          (head),
      .qstat         (qstat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_last  (rsp_run_last)
   );

endmodule
